/* rtl/link_event_statistics_counters_macros.svh */
// assertion macros for the link event statistics block
`ifndef LINK_EVENT_STATISTICS_COUNTERS_MACROS_SVH
`define LINK_EVENT_STATISTICS_COUNTERS_MACROS_SVH

// same-cycle implication, disabled in reset
`define LESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lesc assertion failed");

// next-cycle implication, disabled in reset
`define LESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lesc assertion failed");

`endif

/* rtl/lesc_pkg.sv */
package lesc_pkg;

  localparam int unsigned LIMIT_WIDTH = 20;
  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 20'd500000;

  localparam int unsigned OP_WIDTH    = 3;
  localparam int unsigned IFACE_WIDTH = 8;
  localparam int unsigned FIELD_WIDTH = 16;
  localparam int unsigned TIME_WIDTH  = 64;
  localparam int unsigned INDEX_WIDTH = 5;
  localparam int unsigned DATA_WIDTH  = 64;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_INTERRUPT = 3'd0,
    OP_OUTPUT    = 3'd1,
    OP_DROP      = 3'd2,
    OP_RESTART   = 3'd3,
    OP_STOP      = 3'd4,
    OP_READ      = 3'd5
  } op_e;

  // counter numbering for reads
  localparam logic [INDEX_WIDTH-1:0] CNT_START_TIME     = 5'd0;
  localparam logic [INDEX_WIDTH-1:0] CNT_STOP_TIME      = 5'd1;
  localparam logic [INDEX_WIDTH-1:0] CNT_INT_COUNT      = 5'd2;
  localparam logic [INDEX_WIDTH-1:0] CNT_INT_KICK_COUNT = 5'd3;
  localparam logic [INDEX_WIDTH-1:0] CNT_RX_MIN         = 5'd4;
  localparam logic [INDEX_WIDTH-1:0] CNT_RX_SUM         = 5'd5;
  localparam logic [INDEX_WIDTH-1:0] CNT_RX_MAX         = 5'd6;
  localparam logic [INDEX_WIDTH-1:0] CNT_INT_FREED_MIN  = 5'd7;
  localparam logic [INDEX_WIDTH-1:0] CNT_INT_FREED_SUM  = 5'd8;
  localparam logic [INDEX_WIDTH-1:0] CNT_INT_FREED_MAX  = 5'd9;
  localparam logic [INDEX_WIDTH-1:0] CNT_OUT_COUNT      = 5'd10;
  localparam logic [INDEX_WIDTH-1:0] CNT_OUT_KICK_COUNT = 5'd11;
  localparam logic [INDEX_WIDTH-1:0] CNT_DROP_COUNT     = 5'd12;
  localparam logic [INDEX_WIDTH-1:0] CNT_OUT_FREED_MIN  = 5'd13;
  localparam logic [INDEX_WIDTH-1:0] CNT_OUT_FREED_SUM  = 5'd14;
  localparam logic [INDEX_WIDTH-1:0] CNT_OUT_FREED_MAX  = 5'd15;
  localparam logic [INDEX_WIDTH-1:0] CNT_OUT_BYTES      = 5'd16;
  localparam logic [INDEX_WIDTH-1:0] CNT_DROP_BYTES     = 5'd17;

  // one input request as held in the input register
  typedef struct packed {
    logic [OP_WIDTH-1:0]    operation;
    logic [IFACE_WIDTH-1:0] interface_req;
    logic [FIELD_WIDTH-1:0] rx_taken;
    logic [FIELD_WIDTH-1:0] tx_released;
    logic [FIELD_WIDTH-1:0] tx_len;
    logic                   kicked;
    logic [TIME_WIDTH-1:0]  timestamp;
    logic [INDEX_WIDTH-1:0] counter_index;
  } item_t;

endpackage

/* rtl/link_event_statistics_counters.sv */
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | operation .. counter_index
// out     | output    | out_valid_o / out_stall_i | read_data .. counted
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (interrupt limit)
//
// one request per cycle sustained while out_stall_i stays low
// latency is set by the input register and the result register around the update logic
// collection state changes only as a request moves from the input to the result register
// reset clears all counters, running_q and ready_q, and loads the default interrupt limit
// a stalled result keeps one more request in the input register before in_stall_o rises

`include "link_event_statistics_counters_macros.svh"

module link_event_statistics_counters
  import lesc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COUNT_WIDTH  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input requests
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [OP_WIDTH-1:0]    operation_i,
  input  logic [IFACE_WIDTH-1:0] interface_req_i,
  input  logic [FIELD_WIDTH-1:0] rx_taken_i,
  input  logic [FIELD_WIDTH-1:0] tx_released_i,
  input  logic [FIELD_WIDTH-1:0] tx_len_i,
  input  logic                   kicked_i,
  input  logic [TIME_WIDTH-1:0]  timestamp_i,
  input  logic [INDEX_WIDTH-1:0] counter_index_i,
  // results
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DATA_WIDTH-1:0]  read_data_o,
  output logic                   collecting_o,
  output logic                   results_ready_o,
  output logic                   counted_o,
  // limit register write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LIMIT_WIDTH-1:0] cfg_data_i
);

  // sums and byte totals are capped at 64 bits
  localparam int unsigned SUM_WIDTH =
    (SAMPLE_WIDTH + COUNT_WIDTH > 64) ? 64 : SAMPLE_WIDTH + COUNT_WIDTH;

  typedef logic [SAMPLE_WIDTH-1:0] smp_t;
  typedef logic [COUNT_WIDTH-1:0]  cnt_t;
  typedef logic [SUM_WIDTH-1:0]    sum_t;

  // saturating increment of a count
  function automatic cnt_t cnt_inc(input cnt_t a);
    cnt_inc = (a == '1) ? a : a + COUNT_WIDTH'(1);
  endfunction

  // saturating add into a sum
  function automatic sum_t sum_add(input sum_t a, input sum_t x);
    logic [SUM_WIDTH:0] t;
    t = {1'b0, a} + {1'b0, x};
    sum_add = t[SUM_WIDTH] ? '1 : t[SUM_WIDTH-1:0];
  endfunction

  // handshake and pipeline control
  item_t item_q;
  logic  s1_valid_q, s1_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  s1_take, s2_ready, s2_fire;

  // configuration
  logic [LIMIT_WIDTH-1:0] limit_q, limit_d;

  // collection state
  logic                   running_q, running_d;
  logic                   ready_q, ready_d;
  logic [IFACE_WIDTH-1:0] watched_q, watched_d;
  logic [TIME_WIDTH-1:0]  start_time_q, start_time_d;
  logic [TIME_WIDTH-1:0]  stop_time_q, stop_time_d;
  cnt_t int_cnt_q, int_cnt_d;
  cnt_t int_kick_q, int_kick_d;
  smp_t rx_min_q, rx_min_d;
  sum_t rx_sum_q, rx_sum_d;
  smp_t rx_max_q, rx_max_d;
  smp_t if_min_q, if_min_d;
  sum_t if_sum_q, if_sum_d;
  smp_t if_max_q, if_max_d;
  cnt_t out_cnt_q, out_cnt_d;
  cnt_t out_kick_q, out_kick_d;
  cnt_t drop_cnt_q, drop_cnt_d;
  smp_t of_min_q, of_min_d;
  sum_t of_sum_q, of_sum_d;
  smp_t of_max_q, of_max_d;
  sum_t out_bytes_q, out_bytes_d;
  sum_t drop_bytes_q, drop_bytes_d;

  // result register
  logic [DATA_WIDTH-1:0] read_data_q, read_data_d;
  logic                  collecting_q, results_ready_q;
  logic                  counted_q, counted_d;

  // request decode
  op_e  op;
  logic hit;
  logic first;
  smp_t rx_s, freed_s;
  sum_t len_s;

  // input register fills whenever it is empty or drains this cycle
  assign s2_ready   = !out_valid_q || !out_stall_i;
  assign s2_fire    = s1_valid_q && s2_ready;
  assign in_stall_o = s1_valid_q && !s2_ready;
  assign s1_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_take) begin
      s1_valid_d = 1'b1;
    end else if (s2_fire) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    limit_d = limit_q;
    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end
  end

  assign op      = op_e'(item_q.operation);
  assign hit     = running_q && (item_q.interface_req == watched_q);
  assign rx_s    = SAMPLE_WIDTH'(item_q.rx_taken);
  assign freed_s = SAMPLE_WIDTH'(item_q.tx_released);
  assign len_s   = SUM_WIDTH'(item_q.tx_len);

  // state update for the request in the input register
  always_comb begin
    running_d    = running_q;
    ready_d      = ready_q;
    watched_d    = watched_q;
    start_time_d = start_time_q;
    stop_time_d  = stop_time_q;
    int_cnt_d    = int_cnt_q;
    int_kick_d   = int_kick_q;
    rx_min_d     = rx_min_q;
    rx_sum_d     = rx_sum_q;
    rx_max_d     = rx_max_q;
    if_min_d     = if_min_q;
    if_sum_d     = if_sum_q;
    if_max_d     = if_max_q;
    out_cnt_d    = out_cnt_q;
    out_kick_d   = out_kick_q;
    drop_cnt_d   = drop_cnt_q;
    of_min_d     = of_min_q;
    of_sum_d     = of_sum_q;
    of_max_d     = of_max_q;
    out_bytes_d  = out_bytes_q;
    drop_bytes_d = drop_bytes_q;
    read_data_d  = '0;
    counted_d    = 1'b0;
    first        = 1'b0;

    unique case (op)
      OP_INTERRUPT: begin
        if (hit) begin
          first     = (int_cnt_q == '0);
          int_cnt_d = cnt_inc(int_cnt_q);
          if (item_q.kicked) begin
            int_kick_d = cnt_inc(int_kick_q);
          end
          rx_min_d  = (first || rx_s < rx_min_q) ? rx_s : rx_min_q;
          rx_max_d  = (first || rx_s > rx_max_q) ? rx_s : rx_max_q;
          rx_sum_d  = sum_add(rx_sum_q, SUM_WIDTH'(rx_s));
          if_min_d  = (first || freed_s < if_min_q) ? freed_s : if_min_q;
          if_max_d  = (first || freed_s > if_max_q) ? freed_s : if_max_q;
          if_sum_d  = sum_add(if_sum_q, SUM_WIDTH'(freed_s));
          counted_d = 1'b1;
          // limit reached: collection ends here
          if (int_cnt_d >= COUNT_WIDTH'(limit_q)) begin
            stop_time_d = item_q.timestamp;
            running_d   = 1'b0;
            ready_d     = 1'b1;
          end
        end
      end
      OP_OUTPUT: begin
        if (hit) begin
          first     = (out_cnt_q == '0);
          out_cnt_d = cnt_inc(out_cnt_q);
          if (item_q.kicked) begin
            out_kick_d = cnt_inc(out_kick_q);
          end
          of_min_d    = (first || freed_s < of_min_q) ? freed_s : of_min_q;
          of_max_d    = (first || freed_s > of_max_q) ? freed_s : of_max_q;
          of_sum_d    = sum_add(of_sum_q, SUM_WIDTH'(freed_s));
          out_bytes_d = sum_add(out_bytes_q, len_s);
          counted_d   = 1'b1;
        end
      end
      OP_DROP: begin
        if (hit) begin
          drop_cnt_d   = cnt_inc(drop_cnt_q);
          drop_bytes_d = sum_add(drop_bytes_q, len_s);
          counted_d    = 1'b1;
        end
      end
      OP_RESTART: begin
        // fresh collection; ready flag and stop time stay as they are
        start_time_d = item_q.timestamp;
        watched_d    = item_q.interface_req;
        running_d    = 1'b1;
        int_cnt_d    = '0;
        int_kick_d   = '0;
        rx_min_d     = '0;
        rx_sum_d     = '0;
        rx_max_d     = '0;
        if_min_d     = '0;
        if_sum_d     = '0;
        if_max_d     = '0;
        out_cnt_d    = '0;
        out_kick_d   = '0;
        drop_cnt_d   = '0;
        of_min_d     = '0;
        of_sum_d     = '0;
        of_max_d     = '0;
        out_bytes_d  = '0;
        drop_bytes_d = '0;
      end
      OP_STOP: begin
        // stop while stopped latches nothing
        if (running_q) begin
          stop_time_d = item_q.timestamp;
          running_d   = 1'b0;
          ready_d     = 1'b1;
        end
      end
      OP_READ: begin
        unique case (item_q.counter_index)
          CNT_START_TIME:     read_data_d = start_time_q;
          CNT_STOP_TIME:      read_data_d = stop_time_q;
          CNT_INT_COUNT:      read_data_d = DATA_WIDTH'(int_cnt_q);
          CNT_INT_KICK_COUNT: read_data_d = DATA_WIDTH'(int_kick_q);
          CNT_RX_MIN:         read_data_d = DATA_WIDTH'(rx_min_q);
          CNT_RX_SUM:         read_data_d = DATA_WIDTH'(rx_sum_q);
          CNT_RX_MAX:         read_data_d = DATA_WIDTH'(rx_max_q);
          CNT_INT_FREED_MIN:  read_data_d = DATA_WIDTH'(if_min_q);
          CNT_INT_FREED_SUM:  read_data_d = DATA_WIDTH'(if_sum_q);
          CNT_INT_FREED_MAX:  read_data_d = DATA_WIDTH'(if_max_q);
          CNT_OUT_COUNT:      read_data_d = DATA_WIDTH'(out_cnt_q);
          CNT_OUT_KICK_COUNT: read_data_d = DATA_WIDTH'(out_kick_q);
          CNT_DROP_COUNT:     read_data_d = DATA_WIDTH'(drop_cnt_q);
          CNT_OUT_FREED_MIN:  read_data_d = DATA_WIDTH'(of_min_q);
          CNT_OUT_FREED_SUM:  read_data_d = DATA_WIDTH'(of_sum_q);
          CNT_OUT_FREED_MAX:  read_data_d = DATA_WIDTH'(of_max_q);
          CNT_OUT_BYTES:      read_data_d = DATA_WIDTH'(out_bytes_q);
          CNT_DROP_BYTES:     read_data_d = DATA_WIDTH'(drop_bytes_q);
          default:            read_data_d = '0;
        endcase
      end
      // unused codes leave everything alone
      default: ;
    endcase
  end

  // control state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      limit_q      <= LIMIT_RESET;
      running_q    <= 1'b0;
      ready_q      <= 1'b0;
      watched_q    <= '0;
      start_time_q <= '0;
      stop_time_q  <= '0;
      int_cnt_q    <= '0;
      int_kick_q   <= '0;
      rx_min_q     <= '0;
      rx_sum_q     <= '0;
      rx_max_q     <= '0;
      if_min_q     <= '0;
      if_sum_q     <= '0;
      if_max_q     <= '0;
      out_cnt_q    <= '0;
      out_kick_q   <= '0;
      drop_cnt_q   <= '0;
      of_min_q     <= '0;
      of_sum_q     <= '0;
      of_max_q     <= '0;
      out_bytes_q  <= '0;
      drop_bytes_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      limit_q     <= limit_d;
      if (s2_fire) begin
        running_q    <= running_d;
        ready_q      <= ready_d;
        watched_q    <= watched_d;
        start_time_q <= start_time_d;
        stop_time_q  <= stop_time_d;
        int_cnt_q    <= int_cnt_d;
        int_kick_q   <= int_kick_d;
        rx_min_q     <= rx_min_d;
        rx_sum_q     <= rx_sum_d;
        rx_max_q     <= rx_max_d;
        if_min_q     <= if_min_d;
        if_sum_q     <= if_sum_d;
        if_max_q     <= if_max_d;
        out_cnt_q    <= out_cnt_d;
        out_kick_q   <= out_kick_d;
        drop_cnt_q   <= drop_cnt_d;
        of_min_q     <= of_min_d;
        of_sum_q     <= of_sum_d;
        of_max_q     <= of_max_d;
        out_bytes_q  <= out_bytes_d;
        drop_bytes_q <= drop_bytes_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      item_q.operation     <= operation_i;
      item_q.interface_req <= interface_req_i;
      item_q.rx_taken      <= rx_taken_i;
      item_q.tx_released   <= tx_released_i;
      item_q.tx_len        <= tx_len_i;
      item_q.kicked        <= kicked_i;
      item_q.timestamp     <= timestamp_i;
      item_q.counter_index <= counter_index_i;
    end
    if (s2_fire) begin
      read_data_q     <= read_data_d;
      collecting_q    <= running_d;
      results_ready_q <= ready_d;
      counted_q       <= counted_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign collecting_o    = collecting_q;
  assign results_ready_o = results_ready_q;
  assign counted_o       = counted_q;

  // a counted event never carries read data
  `LESC_ASSERT_NOW(a_counted_no_data, clk_i, rst_ni, out_valid_o && counted_o, read_data_o == '0)
  // an accepted stop while running ends collection with results
  `LESC_ASSERT_NEXT(a_stop_halts, clk_i, rst_ni, s2_fire && op == OP_STOP && running_q, ready_q && !running_q)
  // a restart starts collection from cleared counts
  `LESC_ASSERT_NEXT(a_restart_clears, clk_i, rst_ni, s2_fire && op == OP_RESTART, running_q && int_cnt_q == '0 && out_cnt_q == '0 && drop_cnt_q == '0)

endmodule
